>>> src/u8esc_pkg.sv
// Shared types, constants and byte classification functions for the UTF-8 escape filter.
package u8esc_pkg;

    localparam logic [7:0] BACKSLASH_CHAR = 8'h5C;
    localparam logic [7:0] X_CHAR         = 8'h78;
    localparam logic [7:0] SPACE_CHAR     = 8'h20;
    localparam logic [7:0] DEL_CHAR       = 8'h7F;
    localparam logic [7:0] CONT_MASK      = 8'hC0;
    localparam logic [7:0] CONT_TAG       = 8'h80;
    localparam int         BUF_DEPTH      = 4;
    localparam int         HELD_DEPTH     = 3;

    localparam logic [7:0] HEX_DIGITS [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
    };

    typedef enum logic [1:0] {
        SUB_BACKSLASH = 2'd0,
        SUB_X         = 2'd1,
        SUB_HI        = 2'd2,
        SUB_LO        = 2'd3
    } t_sub;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       string_last;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] out_char;
        logic       run_last;
        logic       string_end;
        logic       lossy;
    } t_out_beat;

    typedef struct packed {
        logic [7:0] tok_byte;
        logic       esc;
    } t_token;

    typedef struct packed {
        t_token [BUF_DEPTH-1:0] tok;
        logic [2:0]             count;
        logic                   string_end;
        logic                   lossy;
    } t_burst;

    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] len;
        len = 3'd0;
        if (b <= 8'h7F) begin
            len = 3'd1;
        end else if (b >= 8'hC2 && b <= 8'hDF) begin
            len = 3'd2;
        end else if (b >= 8'hE0 && b <= 8'hEF) begin
            len = 3'd3;
        end else if (b >= 8'hF0 && b <= 8'hF4) begin
            len = 3'd4;
        end
        return len;
    endfunction

    function automatic logic follow_ok(input logic [7:0] lead, input logic first,
                                       input logic [7:0] b);
        logic ok;
        ok = (b & CONT_MASK) == CONT_TAG;
        if (first) begin
            case (lead)
                8'hE0:   ok = b inside {[8'hA0:8'hBF]};
                8'hED:   ok = b inside {[8'h80:8'h9F]};
                8'hF0:   ok = b inside {[8'h90:8'hBF]};
                8'hF4:   ok = b inside {[8'h80:8'h8F]};
                default: ok = (b & CONT_MASK) == CONT_TAG;
            endcase
        end
        return ok;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        return HEX_DIGITS[nib];
    endfunction

endpackage

>>> src/u8esc_scan.sv
// Sequence decoder: splits held bytes plus one new byte into pass and escape tokens.
module u8esc_scan
    import u8esc_pkg::*;
(
    input  t_in_beat                  i_in,
    input  logic [HELD_DEPTH-1:0][7:0] i_held_bytes,
    input  logic [1:0]                i_held_count,
    input  logic                      i_lossy_seen,
    output t_burst                    o_burst,
    output logic [HELD_DEPTH-1:0][7:0] o_held_bytes,
    output logic [1:0]                o_held_count,
    output logic                      o_lossy_seen
);

    always_comb begin
        logic [BUF_DEPTH-1:0][7:0] buf_b;
        logic [2:0] n;
        logic [2:0] pos;
        logic [2:0] cnt;
        logic [2:0] len;
        logic [2:0] avail;
        logic [7:0] lead;
        logic       done;
        logic       fail;
        logic       any_esc;
        logic       last;

        last = i_in.string_last;
        for (int i = 0; i < HELD_DEPTH; i++) begin
            buf_b[i] = (2'(i) < i_held_count) ? i_held_bytes[i] : i_in.in_byte;
        end
        buf_b[BUF_DEPTH-1] = i_in.in_byte;
        n        = {1'b0, i_held_count} + 3'd1;
        pos      = 3'd0;
        cnt      = 3'd0;
        done     = 1'b0;
        any_esc  = 1'b0;
        o_burst  = '0;
        o_held_bytes = i_held_bytes;
        o_held_count = 2'd0;

        for (int p = 0; p < BUF_DEPTH; p++) begin
            lead  = buf_b[p];
            len   = lead_len(lead);
            avail = n - 3'(p);
            fail  = 1'b0;
            if (!done && 3'(p) < n && 3'(p) == pos) begin
                if (len == 3'd0) begin
                    o_burst.tok[cnt[1:0]] = '{tok_byte: lead, esc: 1'b1};
                    cnt     = cnt + 3'd1;
                    any_esc = 1'b1;
                    pos     = pos + 3'd1;
                end else if (len == 3'd1) begin
                    if (lead < SPACE_CHAR || lead == DEL_CHAR) begin
                        o_burst.tok[cnt[1:0]] = '{tok_byte: lead, esc: 1'b1};
                        any_esc = 1'b1;
                    end else begin
                        o_burst.tok[cnt[1:0]] = '{tok_byte: lead, esc: 1'b0};
                    end
                    cnt = cnt + 3'd1;
                    pos = pos + 3'd1;
                end else begin
                    for (int k = 1; k < BUF_DEPTH; k++) begin
                        if (p + k < BUF_DEPTH && 3'(k) < avail && 3'(k) < len) begin
                            if (!follow_ok(lead, k == 1, buf_b[2'(p + k)])) begin
                                fail = 1'b1;
                            end
                        end
                    end
                    if (fail || (avail < len && last)) begin
                        o_burst.tok[cnt[1:0]] = '{tok_byte: lead, esc: 1'b1};
                        cnt     = cnt + 3'd1;
                        any_esc = 1'b1;
                        pos     = pos + 3'd1;
                    end else if (avail >= len) begin
                        for (int k = 0; k < BUF_DEPTH; k++) begin
                            if (p + k < BUF_DEPTH && 3'(k) < len) begin
                                o_burst.tok[cnt[1:0]] =
                                    '{tok_byte: buf_b[2'(p + k)], esc: 1'b0};
                                cnt = cnt + 3'd1;
                            end
                        end
                        pos = pos + len;
                    end else begin
                        for (int k = 0; k < HELD_DEPTH; k++) begin
                            if (p + k < BUF_DEPTH && 3'(k) < avail) begin
                                o_held_bytes[k] = buf_b[2'(p + k)];
                            end
                        end
                        o_held_count = avail[1:0];
                        done = 1'b1;
                    end
                end
            end
        end

        o_burst.count      = cnt;
        o_burst.string_end = last;
        o_burst.lossy      = i_lossy_seen | any_esc;
        o_lossy_seen       = last ? 1'b0 : (i_lossy_seen | any_esc);
    end

endmodule

>>> src/u8esc_burst.sv
// Output sequencer: holds one decoded token burst and emits one character beat per cycle while not stalled.
module u8esc_burst
    import u8esc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_burst    i_burst,
    output logic      o_free,
    output logic      o_valid,
    output t_out_beat o_out,
    input  logic      i_stall
);

    t_burst     r_burst;
    logic       r_valid;
    logic [1:0] r_slot;
    t_sub       r_sub;
    t_token     cur_tok;
    logic       slot_done;
    logic       final_beat;
    logic       take;

    assign cur_tok    = r_burst.tok[r_slot];
    assign slot_done  = !cur_tok.esc || r_sub == SUB_LO;
    assign final_beat = slot_done && ({1'b0, r_slot} == r_burst.count - 3'd1);
    assign take       = r_valid && !i_stall;
    assign o_free     = !r_valid || (take && final_beat);
    assign o_valid    = r_valid;

    always_comb begin
        o_out = '0;
        if (cur_tok.esc) begin
            case (r_sub)
                SUB_BACKSLASH: o_out.out_char = BACKSLASH_CHAR;
                SUB_X:         o_out.out_char = X_CHAR;
                SUB_HI:        o_out.out_char = hex_char(cur_tok.tok_byte[7:4]);
                SUB_LO:        o_out.out_char = hex_char(cur_tok.tok_byte[3:0]);
                default:       o_out.out_char = BACKSLASH_CHAR;
            endcase
        end else begin
            o_out.out_char = cur_tok.tok_byte;
        end
        o_out.run_last   = final_beat;
        o_out.string_end = final_beat && r_burst.string_end;
        o_out.lossy      = final_beat && r_burst.string_end && r_burst.lossy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_slot  <= 2'd0;
            r_sub   <= SUB_BACKSLASH;
        end else if (i_load && o_free) begin
            r_valid <= 1'b1;
            r_slot  <= 2'd0;
            r_sub   <= SUB_BACKSLASH;
        end else if (take) begin
            if (final_beat) begin
                r_valid <= 1'b0;
            end else if (slot_done) begin
                r_slot <= r_slot + 2'd1;
                r_sub  <= SUB_BACKSLASH;
            end else begin
                r_sub <= t_sub'(r_sub + 2'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_free) begin
            r_burst <= i_burst;
        end
    end

`ifndef ASSERT_OFF
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> r_burst.count != 3'd0)
        else $error("burst held with no tokens");

    a_slot_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> {1'b0, r_slot} < r_burst.count)
        else $error("slot index past token count");

    a_plain_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !cur_tok.esc |-> r_sub == SUB_BACKSLASH)
        else $error("plain token advanced past its only beat");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && i_stall |=> r_valid && $stable(r_slot) && $stable(r_sub))
        else $error("sequencer advanced while stalled");
`endif

endmodule

>>> src/utf8_strict_escape_filter.sv
// Top level of the strict UTF-8 filter with hex escapes for invalid and control bytes.
//
//   channel | direction | handshake          | payload
//   input   | in        | i_valid / o_stall  | i_in  (in_byte, string_last)
//   output  | out       | o_valid / i_stall  | o_out (out_char, run_last, string_end, lossy)
//
// An input beat is registered, decoded combinationally against the held partial sequence,
// and its result burst goes to the output sequencer, which emits one beat per cycle unless
// stalled. A byte with no result is consumed without waiting; a burst of up to 16 beats
// holds the next byte until the single-beat sequencer takes its final beat. The first beat
// is driven once the burst is loaded. Reset clears held count, lossy flag and all valid flags.
// Output stall holds the sequencer, which in turn stalls the input register.
module utf8_strict_escape_filter
    import u8esc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_in_beat  i_in,
    output logic      o_stall,
    output logic      o_valid,
    output t_out_beat o_out,
    input  logic      i_stall
);

    t_in_beat                   r_in;
    logic                       r_in_valid;
    logic [HELD_DEPTH-1:0][7:0] r_held_bytes;
    logic [1:0]                 r_held_count;
    logic                       r_lossy_seen;

    t_burst                     n_burst;
    logic [HELD_DEPTH-1:0][7:0] n_held_bytes;
    logic [1:0]                 n_held_count;
    logic                       n_lossy_seen;
    logic                       burst_free;
    logic                       consume;
    logic                       accept;

    u8esc_scan u_scan (
        .i_in         (r_in),
        .i_held_bytes (r_held_bytes),
        .i_held_count (r_held_count),
        .i_lossy_seen (r_lossy_seen),
        .o_burst      (n_burst),
        .o_held_bytes (n_held_bytes),
        .o_held_count (n_held_count),
        .o_lossy_seen (n_lossy_seen)
    );

    u8esc_burst u_burst (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (consume && n_burst.count != 3'd0),
        .i_burst (n_burst),
        .o_free  (burst_free),
        .o_valid (o_valid),
        .o_out   (o_out),
        .i_stall (i_stall)
    );

    assign consume = r_in_valid && (burst_free || n_burst.count == 3'd0);
    assign o_stall = r_in_valid && !consume;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_held_count <= 2'd0;
            r_lossy_seen <= 1'b0;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (consume) begin
                r_in_valid <= 1'b0;
            end
            if (consume) begin
                r_held_count <= n_held_count;
                r_lossy_seen <= n_lossy_seen;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_in;
        end
        if (consume) begin
            r_held_bytes <= n_held_bytes;
        end
    end

`ifndef ASSERT_OFF
    a_last_settles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        consume && r_in.string_last |=> r_held_count == 2'd0 && !r_lossy_seen)
        else $error("state left over after string end");

    a_last_has_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        consume && r_in.string_last |-> n_burst.count != 3'd0)
        else $error("final byte produced no output");

    a_hold_no_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        consume && n_held_count != 2'd0 |-> !r_in.string_last)
        else $error("bytes held at string end");
`endif

endmodule
